// ----- design/smpq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package smpq_pkg;

  localparam int KEY_W   = 32;
  localparam int SEQ_W   = 32;
  localparam int ENTRY_W = KEY_W + SEQ_W;

  // Flip the sign bit so unsigned order of the stored key equals signed order.
  localparam logic [KEY_W-1:0] SIGN_FLIP = 32'h8000_0000;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic                    cmd;
    logic signed [KEY_W-1:0] key_in;
  } in_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] popped_key;
    logic [1:0]              status;
    logic [7:0]              entries_now;
    logic signed [KEY_W-1:0] smallest_key;
  } out_t;

  // Heap entry: biased key above sequence number, compared as one unsigned word.
  typedef struct packed {
    logic [KEY_W-1:0] kb;
    logic [SEQ_W-1:0] seq;
  } entry_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic    accept;
    logic    push_go;
    logic    pop_go;
    logic    up_rd;
    logic    up_move;
    logic    up_place;
    logic    last_rd;
    logic    last_ld;
    logic    dn_rd;
    logic    dn_move;
    logic    dn_place;
    logic    report;
    status_t status;
  } ctl_t;

  // Datapath to controller status.
  typedef struct packed {
    logic full;
    logic empty;
    logic pos_zero;
    logic parent_gt;
    logic left_out;
    logic child_lt;
  } sts_t;

endpackage

`default_nettype wire

// ----- design/stable_min_priority_queue_unit.sv -----
// Channel   Ports                         Transaction
// input     start, busy, in_data          start high while busy low
// result    out_valid, out_data           out_valid high for one cycle
//
// A push climbs one level at a time until a parent stops it or it reaches the
// root. A pop moves the last entry to the root and sinks it one level at a time
// until a child stops it or it reaches a leaf. Each level is one heap memory
// read and one compare-and-write; a failed push or pop, or a pop that empties the
// queue, goes straight to the report. busy is high from accept until the strobe.
// Synchronous active-low reset empties the queue; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module stable_min_priority_queue_unit import smpq_pkg::*; #(
  parameter int CAPACITY = 128
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  ctl_t ctl;
  sts_t sts;

  smpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_data.cmd),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid)
  );

  smpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .ctl      (ctl),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ----- design/smpq_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module smpq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic      [WIDTH-1:0]         rdata_a,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic      [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a <= mem_r[raddr_a];
    rdata_b <= mem_r[raddr_b];
  end

endmodule

`default_nettype wire

// ----- design/smpq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module smpq_datapath import smpq_pkg::*; #(
  parameter int CAPACITY = 128
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire in_t  in_data,
  input  wire ctl_t ctl,
  output sts_t      sts,
  output out_t      out_data
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = CW + 1;

  logic [CW-1:0]    count_r;
  logic [SEQ_W-1:0] seq_r;
  logic [AW-1:0]    pos_r;
  entry_t           e_r;
  entry_t           root_r;
  logic [KEY_W-1:0] popped_r;
  out_t             out_r;

  entry_t           rd_a;
  entry_t           rd_b;
  logic [AW-1:0]    raddr_a;
  logic [AW-1:0]    parent;
  logic [PW-1:0]    left;
  logic [PW-1:0]    right;
  logic             right_ok;
  logic             take_right;
  entry_t           child;
  logic             we;
  entry_t           wdata;

  assign parent     = (pos_r - AW'(1)) >> 1;
  assign left       = PW'({pos_r, 1'b1});
  assign right      = left + PW'(1);
  assign right_ok   = right < PW'(count_r);
  assign take_right = right_ok && (rd_b < rd_a);
  assign child      = take_right ? rd_b : rd_a;

  always_comb begin
    raddr_a = left[AW-1:0];
    if (ctl.up_rd) begin
      raddr_a = parent;
    end else if (ctl.last_rd) begin
      raddr_a = count_r[AW-1:0];
    end
  end

  assign we = ctl.up_move | ctl.up_place | ctl.dn_move | ctl.dn_place;

  always_comb begin
    wdata = e_r;
    if (ctl.up_move) begin
      wdata = rd_a;
    end else if (ctl.dn_move) begin
      wdata = child;
    end
  end

  smpq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .we      (we),
    .waddr   (pos_r),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .rdata_a (rd_a),
    .raddr_b (right[AW-1:0]),
    .rdata_b (rd_b)
  );

  assign sts.full      = count_r == CW'(CAPACITY);
  assign sts.empty     = count_r == '0;
  assign sts.pos_zero  = pos_r == '0;
  assign sts.parent_gt = rd_a > e_r;
  assign sts.left_out  = left >= PW'(count_r);
  assign sts.child_lt  = child < e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      seq_r   <= '0;
    end else begin
      if (ctl.push_go) begin
        count_r <= count_r + CW'(1);
        seq_r   <= seq_r + SEQ_W'(1);
      end else if (ctl.pop_go) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push_go) begin
      e_r   <= '{kb: in_data.key_in ^ SIGN_FLIP, seq: seq_r};
      pos_r <= count_r[AW-1:0];
    end else if (ctl.last_ld) begin
      e_r   <= rd_a;
      pos_r <= '0;
    end else if (ctl.up_move) begin
      pos_r <= parent;
    end else if (ctl.dn_move) begin
      pos_r <= take_right ? right[AW-1:0] : left[AW-1:0];
    end
    // Mirror slot zero so the smallest key needs no memory read.
    if (we && pos_r == '0) begin
      root_r <= wdata;
    end
    if (ctl.accept) begin
      popped_r <= ctl.pop_go ? (root_r.kb ^ SIGN_FLIP) : '0;
    end
    if (ctl.report) begin
      out_r.popped_key   <= popped_r;
      out_r.status       <= ctl.status;
      out_r.entries_now  <= 8'(count_r);
      out_r.smallest_key <= (count_r != '0) ? (root_r.kb ^ SIGN_FLIP) : '0;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire

// ----- design/smpq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module smpq_ctrl import smpq_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic in_cmd,
  input  wire sts_t sts,
  output ctl_t      ctl,
  output logic      busy,
  output logic      out_valid
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP_CHK,
    S_UP_CMP,
    S_LAST_RD,
    S_LAST_LD,
    S_DN_CHK,
    S_DN_CMP,
    S_REPORT
  } state_t;

  state_t  state_r, state_nxt;
  status_t st_r, st_nxt;
  logic    out_valid_r;

  always_comb begin
    state_nxt = state_r;
    st_nxt    = STAT_OK;
    ctl       = '0;
    ctl.status = st_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctl.accept = 1'b1;
          if (in_cmd == CMD_PUSH) begin
            if (sts.full) begin
              st_nxt    = STAT_FULL;
              state_nxt = S_REPORT;
            end else begin
              ctl.push_go = 1'b1;
              state_nxt   = S_UP_CHK;
            end
          end else begin
            if (sts.empty) begin
              st_nxt    = STAT_EMPTY;
              state_nxt = S_REPORT;
            end else begin
              ctl.pop_go = 1'b1;
              state_nxt  = S_LAST_RD;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (sts.pos_zero) begin
          ctl.up_place = 1'b1;
          state_nxt    = S_REPORT;
        end else begin
          ctl.up_rd = 1'b1;
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (sts.parent_gt) begin
          ctl.up_move = 1'b1;
          state_nxt   = S_UP_CHK;
        end else begin
          ctl.up_place = 1'b1;
          state_nxt    = S_REPORT;
        end
      end
      S_LAST_RD: begin
        // Count is already decremented: the last entry sits at slot count.
        if (sts.empty) begin
          state_nxt = S_REPORT;
        end else begin
          ctl.last_rd = 1'b1;
          state_nxt   = S_LAST_LD;
        end
      end
      S_LAST_LD: begin
        ctl.last_ld = 1'b1;
        state_nxt   = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (sts.left_out) begin
          ctl.dn_place = 1'b1;
          state_nxt    = S_REPORT;
        end else begin
          ctl.dn_rd = 1'b1;
          state_nxt = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (sts.child_lt) begin
          ctl.dn_move = 1'b1;
          state_nxt   = S_DN_CHK;
        end else begin
          ctl.dn_place = 1'b1;
          state_nxt    = S_REPORT;
        end
      end
      S_REPORT: begin
        ctl.report = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      st_r        <= STAT_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= ctl.report;
      if (ctl.accept) begin
        st_r <= st_nxt;
      end
    end
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// ----- test/heap_result_monitor.sv -----
`timescale 1ns / 1ps

module heap_result_monitor import smpq_pkg::*; #(
  parameter int CAPACITY = 128
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic busy,
  input  wire in_t  in_data,
  input  wire logic out_valid,
  input  wire out_t out_data,
  output int        mismatches,
  output int        pending,
  output int        results_seen,
  output int        full_hits,
  output int        empty_hits
);

  // Shadow heap, ordered by the pair (biased key, sequence) as one unsigned word.
  entry_t           heap_mem [CAPACITY];
  int               heap_size = 0;
  logic [SEQ_W-1:0] seq_ctr = '0;
  out_t             expected_q [$];

  initial begin
    mismatches   = 0;
    pending      = 0;
    results_seen = 0;
    full_hits    = 0;
    empty_hits   = 0;
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  // Apply one transaction to the shadow heap and return the result it must produce.
  function automatic out_t heap_apply(input in_t op);
    out_t   r;
    entry_t item;
    entry_t last;
    int     pos;
    int     parent;
    int     left;
    int     child;
    bit     done;
    r        = '0;
    r.status = STAT_OK;
    if (op.cmd == CMD_PUSH) begin
      if (heap_size >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        item.kb  = op.key_in ^ SIGN_FLIP;
        item.seq = seq_ctr;
        pos      = heap_size;
        done     = 1'b0;
        while (pos > 0 && !done) begin
          parent = (pos - 1) / 2;
          if (heap_mem[parent] > item) begin
            heap_mem[pos] = heap_mem[parent];
            pos           = parent;
          end else begin
            done = 1'b1;
          end
        end
        heap_mem[pos] = item;
        heap_size++;
        seq_ctr++;
      end
    end else if (heap_size == 0) begin
      r.status = STAT_EMPTY;
    end else begin
      r.popped_key = heap_mem[0].kb ^ SIGN_FLIP;
      heap_size--;
      last = heap_mem[heap_size];
      if (heap_size > 0) begin
        pos  = 0;
        done = 1'b0;
        while (!done) begin
          left = 2 * pos + 1;
          if (left >= heap_size) begin
            done = 1'b1;
          end else begin
            // Compare against the right child only when it exists.
            child = left;
            if (left + 1 < heap_size && heap_mem[left + 1] < heap_mem[left]) child = left + 1;
            if (heap_mem[child] < last) begin
              heap_mem[pos] = heap_mem[child];
              pos           = child;
            end else begin
              done = 1'b1;
            end
          end
        end
        heap_mem[pos] = last;
      end
    end
    r.entries_now  = 8'(heap_size);
    r.smallest_key = (heap_size > 0) ? (heap_mem[0].kb ^ SIGN_FLIP) : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (rst_n) begin
      // Retire the result first: a new transaction may be accepted on the same edge.
      if (out_valid) begin
        results_seen++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result, popped_key", $signed(out_data.popped_key), 0);
        end else begin
          want = expected_q.pop_front();
          if (want.status == STAT_FULL) full_hits++;
          if (want.status == STAT_EMPTY) empty_hits++;
          if (out_data.popped_key !== want.popped_key)
            report_mismatch("popped_key", $signed(out_data.popped_key), $signed(want.popped_key));
          if (out_data.status !== want.status)
            report_mismatch("status", out_data.status, want.status);
          if (out_data.entries_now !== want.entries_now)
            report_mismatch("entries_now", out_data.entries_now, want.entries_now);
          if (out_data.smallest_key !== want.smallest_key)
            report_mismatch("smallest_key", $signed(out_data.smallest_key),
                            $signed(want.smallest_key));
        end
      end
      if (start && !busy) expected_q.insert(expected_q.size(), heap_apply(in_data));
      pending <= expected_q.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import smpq_pkg::*;

  localparam int DEPTH       = 128;
  localparam int TOTAL_OPS   = 600;
  localparam int STALL_LIMIT = 400;

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic start   = 1'b0;
  in_t  in_data = '0;
  logic busy;
  logic out_valid;
  out_t out_data;

  int mismatches;
  int pending;
  int results_seen;
  int full_hits;
  int empty_hits;

  int ops_sent     = 0;
  int pushes_sent  = 0;
  int pops_sent    = 0;
  int level        = 0;
  int peak_level   = 0;
  int stall_cycles = 0;
  bit quiet        = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  stable_min_priority_queue_unit #(.CAPACITY(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  heap_result_monitor #(.CAPACITY(DEPTH)) result_mon (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_data     (out_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .results_seen (results_seen),
    .full_hits    (full_hits),
    .empty_hits   (empty_hits)
  );

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Mix wide random keys with tight ranges (many ties) and the signed extremes.
  function automatic logic [KEY_W-1:0] pick_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 3))
      0: k = $urandom;
      1: k = KEY_W'($urandom_range(0, 15)) - KEY_W'(8);
      2: k = $urandom_range(0, 1) ? {1'b0, {(KEY_W-1){1'b1}}} : {1'b1, {(KEY_W-1){1'b0}}};
      default: k = KEY_W'($urandom_range(0, 1999)) - KEY_W'(1000);
    endcase
    return k;
  endfunction

  task automatic send_op(input logic op, input logic [KEY_W-1:0] key);
    int gap;
    in_data <= '{cmd: op, key_in: key};
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    ops_sent++;
    if (op == CMD_PUSH) begin
      pushes_sent++;
      if (level < DEPTH) level++;
    end else begin
      pops_sent++;
      if (level > 0) level--;
    end
    if (level > peak_level) peak_level = level;
    // Hold start high through back-to-back transactions; drop it only for a gap.
    gap = quiet ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic random_op(input int push_pct);
    if ($urandom_range(1, 100) <= push_pct) send_op(CMD_PUSH, pick_key());
    else send_op(CMD_POP, $urandom);
  endtask

  task automatic mixed_segment(input int count);
    int pct;
    case ($urandom_range(0, 2))
      0: pct = 25;
      1: pct = 50;
      default: pct = 75;
    endcase
    quiet = ($urandom_range(0, 3) == 0);
    repeat (count) random_op(pct);
  endtask

  initial begin
    logic [KEY_W-1:0] firsts [8];
    firsts = '{32'h0000_0000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
               32'h0000_0001, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pop on empty, extremes, equal keys, drain, pop on empty again.
    send_op(CMD_POP, 32'h0000_0000);
    foreach (firsts[i]) send_op(CMD_PUSH, firsts[i]);
    repeat (8) send_op(CMD_POP, $urandom);
    send_op(CMD_POP, 32'hffff_ffff);
    send_op(CMD_PUSH, 32'hffff_fffb);
    send_op(CMD_PUSH, 32'hffff_fffb);
    send_op(CMD_POP, '0);
    send_op(CMD_POP, '0);

    repeat (5) mixed_segment(40);

    // Fill to capacity, then push into a full queue.
    quiet = ($urandom_range(0, 1) == 0);
    while (level < DEPTH) send_op(CMD_PUSH, pick_key());
    repeat (3) send_op(CMD_PUSH, pick_key());

    // Drain with a few pushes mixed in, then pop an empty queue.
    quiet = 1'b0;
    while (level > 0) random_op(10);
    repeat (2) send_op(CMD_POP, $urandom);

    while (ops_sent < TOTAL_OPS) mixed_segment(40);

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);

    $display("Ran %0d transactions (%0d pushes, %0d pops), checked %0d results.",
             ops_sent, pushes_sent, pops_sent, results_seen);
    $display("Peak occupancy %0d of %0d; %0d pushes on full, %0d pops on empty.",
             peak_level, DEPTH, full_hits, empty_hits);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/smpq_pkg.sv
design/smpq_ram.sv
design/smpq_datapath.sv
design/smpq_ctrl.sv
design/stable_min_priority_queue_unit.sv
test/heap_result_monitor.sv
test/tb_top.sv
